// ===== rtl/pipc_pkg.sv =====
// package for the point-in-polygon crossing test: sizes, codes and state type
`default_nettype none

package pipc_pkg;

    // polygon table size and coordinate width
    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 16;

    // derived widths
    localparam int ADDR_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W   = 6;
    localparam int VCNT_W  = 7;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int VERT_W  = 2 * COORD_W;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/pipc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module pipc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/point_in_polygon_crossing_test_core.sv =====
// top level of the point-in-polygon crossing test: vertex ram, edge walk and crossing pipeline
`default_nettype none

// Even-odd ray-cast point-in-polygon test over a table of up to MAX_VERTICES
// signed Q8.8 vertices held in one synchronous ram. A load word (mode 0)
// writes one vertex and busy stays low. A query word (mode 1) walks the
// polygon one edge per cycle through the ram's single read port: it reads
// the last vertex in use, then vertices 0 to n-1, and feeds each edge
// through a three-stage crossing pipeline (differences, two 17x17 products,
// compare), n being vertex_count capped at MAX_VERTICES. A query holds busy;
// the result appears on inside_res with done high for exactly one cycle,
// the first cycle in which busy is low again, and must be captured then
// since it cannot be held off. With a count of zero the result (outside)
// comes in the cycle after the query is taken. A new word may be started
// in the same cycle that done is high. The user must write vertex_count
// through cfg_we/cfg_wdata only while the block is idle, unenforced by the
// block, and every vertex that a query reaches must have been loaded first.
module point_in_polygon_crossing_test_core
    import pipc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [VCNT_W-1:0]         cfg_wdata,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      mode,
    input  wire logic [IDX_W-1:0]          vertex_index,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    output logic                           done,
    output logic                           inside_res
);

    state_t state_reg, state_next;

    logic [VCNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0]  n_cap;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    logic              accept;
    logic              load_we;
    logic              query_go;
    logic              rd_en;
    logic              rd_last;
    logic [ADDR_W-1:0] rd_addr;
    logic [VERT_W-1:0] rd_data;

    logic rdv_reg, rd_first_reg, rd_last_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] cur_x, cur_y;

    logic s1_valid_reg, s1_last_reg, s1_straddle_reg, s1_dypos_reg;
    logic signed [DIFF_W-1:0] s1_la_reg, s1_lb_reg, s1_ra_reg, s1_rb_reg;

    logic s2_valid_reg, s2_last_reg, s2_straddle_reg, s2_dypos_reg;
    logic signed [PROD_W-1:0] s2_lp_reg, s2_rp_reg;

    logic straddle;
    logic left;
    logic flip;
    logic inside_reg;
    logic done_reg, inside_res_reg;

    // handshake and vertex count cap
    assign accept   = start && !busy;
    assign load_we  = accept && (mode == MODE_LOAD) && (32'(vertex_index) < MAX_VERTICES);
    assign query_go = accept && (mode == MODE_QUERY);
    assign n_cap    = (32'(vertex_count_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                             : CNT_W'(vertex_count_reg);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            vertex_count_reg <= cfg_wdata;
        end
    end

    // vertex ram, x in the upper half and y in the lower half
    pipc_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(vertex_index)),
        .wdata ({coord_x, coord_y}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_go && (n_cap != '0))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (rd_cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: first read fetches the closing vertex n-1
    always_comb
    begin
        busy    = 1'b1;
        rd_en   = 1'b0;
        rd_last = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_WALK:
            begin
                rd_en   = 1'b1;
                rd_last = (rd_cnt_reg == n_reg);
                if (rd_cnt_reg == '0)
                begin
                    rd_addr = ADDR_W'(n_reg - CNT_W'(1));
                end
                else
                begin
                    rd_addr = ADDR_W'(rd_cnt_reg - CNT_W'(1));
                end
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // state and walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (query_go)
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
        end
    end

    // query operands
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            n_reg  <= n_cap;
        end
    end

    // edge setup from the vertex just read and the one before it
    assign cur_x    = rd_data[VERT_W-1:COORD_W];
    assign cur_y    = rd_data[COORD_W-1:0];
    assign straddle = ((cur_y < py_reg) && (prev_y_reg >= py_reg))
                   || ((prev_y_reg < py_reg) && (cur_y >= py_reg));

    // crossing compare, sense follows the edge direction
    assign left = s2_dypos_reg ? (s2_lp_reg < s2_rp_reg) : (s2_rp_reg < s2_lp_reg);
    assign flip = s2_valid_reg && s2_straddle_reg && left;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg        <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            inside_reg     <= 1'b0;
            done_reg       <= 1'b0;
            inside_res_reg <= 1'b0;
        end
        else
        begin
            rdv_reg      <= rd_en;
            rd_first_reg <= rd_en && (rd_cnt_reg == '0);
            rd_last_reg  <= rd_last;
            s1_valid_reg <= rdv_reg && !rd_first_reg;
            s1_last_reg  <= rdv_reg && rd_last_reg;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;

            if (query_go)
            begin
                inside_reg <= 1'b0;
            end
            else if (flip)
            begin
                inside_reg <= !inside_reg;
            end

            // result strobe: empty polygon answers at once
            done_reg <= 1'b0;
            if (query_go && (n_cap == '0))
            begin
                done_reg       <= 1'b1;
                inside_res_reg <= 1'b0;
            end
            else if (s2_valid_reg && s2_last_reg)
            begin
                done_reg       <= 1'b1;
                inside_res_reg <= inside_reg ^ flip;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        s1_straddle_reg <= straddle;
        s1_dypos_reg    <= (prev_y_reg > cur_y);
        s1_la_reg       <= DIFF_W'(py_reg) - DIFF_W'(cur_y);
        s1_lb_reg       <= DIFF_W'(prev_x_reg) - DIFF_W'(cur_x);
        s1_ra_reg       <= DIFF_W'(px_reg) - DIFF_W'(cur_x);
        s1_rb_reg       <= DIFF_W'(prev_y_reg) - DIFF_W'(cur_y);
        s2_straddle_reg <= s1_straddle_reg;
        s2_dypos_reg    <= s1_dypos_reg;
        s2_lp_reg       <= s1_la_reg * s1_lb_reg;
        s2_rp_reg       <= s1_ra_reg * s1_rb_reg;
    end

    assign done       = done_reg;
    assign inside_res = inside_res_reg;

    // a result never shows while a walk is still running
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted query either starts a walk or answers at once
    a_query_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_QUERY)) |=> (busy || done))
        else $error("query accepted but neither walking nor answered");

    // edges only reach the compare stage during a query
    a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> busy)
        else $error("edge in pipeline while idle");

    // a result follows a walk or an empty query, never a load
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && (mode == MODE_QUERY))))
        else $error("result without a query");

endmodule

`default_nettype wire
